// File: rtl/nsr_pkg.sv
// Shared types, constants and command structs for the Newton square root block.
`default_nettype none
package nsr_pkg;

	localparam int unsigned MAX_ITERATIONS_DEF = 64;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_ADDR_W = 1;

	localparam logic [WORD_W-1:0] FP_ONE   = 32'h3F80_0000;
	localparam logic [WORD_W-1:0] FP_THREE = 32'h4040_0000;
	localparam logic [WORD_W-1:0] FP_HALF  = 32'h3F00_0000;
	localparam logic [WORD_W-1:0] FP_DNAN  = 32'hFFC0_0000;
	localparam logic [WORD_W-1:0] FP_QBIT  = 32'h0040_0000;

	localparam logic [WORD_W-1:0] INITIAL_GUESS_RST   = 32'h3F80_0000;
	localparam logic [WORD_W-1:0] ERROR_THRESHOLD_RST = 32'h3727_C5AC;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_INITIAL_GUESS   = 1'b0,
		REG_ERROR_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		FPU_MUL = 1'b0,
		FPU_SUB = 1'b1
	} fpu_op_t;

	typedef enum logic [3:0] {
		STEP_G2,
		STEP_G3,
		STEP_E1,
		STEP_E2,
		STEP_D,
		STEP_A1,
		STEP_B,
		STEP_A2,
		STEP_G,
		STEP_ROOT
	} step_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_WB,
		ST_TEST,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic  issue;
		logic  write;
		logic  load_in;
		logic  load_out;
		logic  not_conv;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic above;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/nsr_fpu.sv
// Three-stage float32 multiply / subtract unit, round to nearest even.
`default_nettype none
module nsr_fpu (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                issue,
	input  wire nsr_pkg::fpu_op_t    op,
	input  wire logic [31:0]         a,
	input  wire logic [31:0]         b,
	output logic                     done,
	output logic [31:0]              result
);

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		begin
			n = 6'd0;
			found = 1'b0;
			for (int i = 47; i >= 0; i--) begin
				if (!found) begin
					if (v[i]) found = 1'b1;
					else n = n + 6'd1;
				end
			end
			return n;
		end
	endfunction

	// stage 1: unpack, specials, product or aligned sum
	logic               spc_c, sign_c;
	logic [31:0]        spc_val_c;
	logic signed [10:0] exp_c;
	logic [47:0]        mag_c;

	logic        sa, sb, sbn, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [7:0]  xa, xb, x_l, x_s, diff;
	logic [23:0] ma, mb, m_l, m_s;
	logic        s_l, a_big;
	logic [47:0] wide_l, wide_s, shf_s;
	logic        lost;

	always_comb begin
		sa = a[31];
		sb = b[31];
		sbn = ~sb;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		ma = {(a[30:23] != 8'd0), a[22:0]};
		mb = {(b[30:23] != 8'd0), b[22:0]};
		xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		xb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		a_big = {xa, ma} >= {xb, mb};
		x_l = a_big ? xa : xb;
		x_s = a_big ? xb : xa;
		m_l = a_big ? ma : mb;
		m_s = a_big ? mb : ma;
		s_l = a_big ? sa : sbn;
		diff = x_l - x_s;
		wide_l = {1'b0, m_l, 23'd0};
		wide_s = {1'b0, m_s, 23'd0};
		shf_s = wide_s >> diff;
		lost = (wide_s & ~({48{1'b1}} << diff)) != 48'd0;
		shf_s[0] = shf_s[0] | lost;

		spc_c = 1'b0;
		spc_val_c = nsr_pkg::FP_DNAN;
		sign_c = 1'b0;
		exp_c = 11'sd0;
		mag_c = 48'd0;
		if (a_nan) begin
			spc_c = 1'b1;
			spc_val_c = a | nsr_pkg::FP_QBIT;
		end else if (b_nan) begin
			spc_c = 1'b1;
			spc_val_c = b | nsr_pkg::FP_QBIT;
		end else if (op == nsr_pkg::FPU_MUL) begin
			sign_c = sa ^ sb;
			if ((a_inf && b_zero) || (a_zero && b_inf)) begin
				spc_c = 1'b1;
				spc_val_c = nsr_pkg::FP_DNAN;
			end else if (a_inf || b_inf) begin
				spc_c = 1'b1;
				spc_val_c = {sa ^ sb, 8'hFF, 23'd0};
			end else begin
				exp_c = $signed({3'b000, xa}) + $signed({3'b000, xb}) - 11'sd127;
				mag_c = ma * mb;
			end
		end else begin
			if (a_inf && b_inf) begin
				spc_c = 1'b1;
				spc_val_c = (sa != sbn) ? nsr_pkg::FP_DNAN : {sa, 8'hFF, 23'd0};
			end else if (a_inf) begin
				spc_c = 1'b1;
				spc_val_c = {sa, 8'hFF, 23'd0};
			end else if (b_inf) begin
				spc_c = 1'b1;
				spc_val_c = {sbn, 8'hFF, 23'd0};
			end else begin
				exp_c = $signed({3'b000, x_l});
				mag_c = (sa == sbn) ? (wide_l + shf_s) : (wide_l - shf_s);
				sign_c = (mag_c == 48'd0) ? (sa & sbn) : s_l;
			end
		end
	end

	logic               v_s1, spc_s1, sign_s1;
	logic [31:0]        spc_val_s1;
	logic signed [10:0] exp_s1;
	logic [47:0]        mag_s1;

	logic               v_s2, spc_s2, sign_s2;
	logic [31:0]        spc_val_s2;
	logic signed [10:0] exp_s2, eb_s2;
	logic [47:0]        mag_s2;
	logic [5:0]         lz_s2;
	logic [5:0]         lz_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		spc_s1 <= spc_c;
		spc_val_s1 <= spc_val_c;
		sign_s1 <= sign_c;
		exp_s1 <= exp_c;
		mag_s1 <= mag_c;
	end

	// stage 2: leading zero count and result exponent
	assign lz_c = lzc48(mag_s1);

	always_ff @(posedge clk) begin
		spc_s2 <= spc_s1;
		spc_val_s2 <= spc_val_s1;
		sign_s2 <= sign_s1;
		exp_s2 <= exp_s1;
		mag_s2 <= mag_s1;
		lz_s2 <= lz_c;
		eb_s2 <= exp_s1 + 11'sd1 - $signed({5'b00000, lz_c});
	end

	// stage 3: normalize or denormalize, round, pack
	logic [47:0] m2, msk;
	logic [10:0] rsh;
	logic        stk, inc;
	logic [7:0]  ef;
	logic [30:0] packed_c;

	always_comb begin
		m2 = 48'd0;
		stk = 1'b0;
		ef = 8'd0;
		rsh = 11'd0;
		msk = 48'd0;
		if (eb_s2 >= 11'sd1) begin
			m2 = mag_s2 << lz_s2;
			ef = eb_s2[7:0];
		end else if (exp_s2 >= 11'sd0) begin
			m2 = mag_s2 << exp_s2[5:0];
		end else begin
			rsh = -exp_s2;
			if (rsh >= 11'd48) begin
				stk = (mag_s2 != 48'd0);
			end else begin
				m2 = mag_s2 >> rsh[5:0];
				msk = ~({48{1'b1}} << rsh[5:0]);
				stk = (mag_s2 & msk) != 48'd0;
			end
		end
		stk = stk | (m2[22:0] != 23'd0);
		inc = m2[23] & (stk | m2[24]);
		packed_c = {ef, m2[46:24]} + {30'd0, inc};

		if (spc_s2) result = spc_val_s2;
		else if (mag_s2 == 48'd0) result = {sign_s2, 31'd0};
		else if (eb_s2 >= 11'sd255) result = {sign_s2, 8'hFF, 23'd0};
		else result = {sign_s2, packed_c};
	end

	assign done = v_s2;

endmodule
`default_nettype wire

// File: rtl/nsr_datapath.sv
// Operand registers, config registers, shared float unit and output register.
`default_nettype none
module nsr_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire nsr_pkg::cmd_t        cmd,
	output nsr_pkg::sts_t             sts,
	input  wire logic                 cfg_we,
	input  wire logic [0:0]           cfg_addr,
	input  wire logic [31:0]          cfg_data,
	input  wire logic [31:0]          in_value,
	input  wire logic                 in_last,
	output logic                      m_valid,
	input  wire logic                 m_ready,
	output logic [31:0]               m_root,
	output logic                      m_nc,
	output logic                      m_last
);

	logic [31:0] init_q, thr_q;
	logic [31:0] x_q, g_q, g2_q, g3_q, e_q, a_q, b_q, d_q, root_q;
	logic        last_q;

	logic [31:0]      opa, opb, res;
	nsr_pkg::fpu_op_t op;
	logic             done;
	logic             d_nan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= nsr_pkg::INITIAL_GUESS_RST;
			thr_q <= nsr_pkg::ERROR_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (nsr_pkg::cfg_reg_t'(cfg_addr))
				nsr_pkg::REG_INITIAL_GUESS:   init_q <= cfg_data;
				nsr_pkg::REG_ERROR_THRESHOLD: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		op = nsr_pkg::FPU_MUL;
		opa = g_q;
		opb = g_q;
		unique case (cmd.step)
			nsr_pkg::STEP_G2:   begin opa = g_q;  opb = g_q; end
			nsr_pkg::STEP_G3:   begin opa = g2_q; opb = g_q; end
			nsr_pkg::STEP_E1:   begin opa = x_q;  opb = g2_q; end
			nsr_pkg::STEP_E2:   begin
				op = nsr_pkg::FPU_SUB; opa = e_q; opb = nsr_pkg::FP_ONE;
			end
			nsr_pkg::STEP_D:    begin op = nsr_pkg::FPU_SUB; opa = e_q; opb = thr_q; end
			nsr_pkg::STEP_A1:   begin opa = g_q;  opb = nsr_pkg::FP_THREE; end
			nsr_pkg::STEP_B:    begin opa = x_q;  opb = g3_q; end
			nsr_pkg::STEP_A2:   begin op = nsr_pkg::FPU_SUB; opa = a_q; opb = b_q; end
			nsr_pkg::STEP_G:    begin opa = a_q;  opb = nsr_pkg::FP_HALF; end
			nsr_pkg::STEP_ROOT: begin opa = g_q;  opb = x_q; end
			default: ;
		endcase
	end

	nsr_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (cmd.issue),
		.op     (op),
		.a      (opa),
		.b      (opb),
		.done   (done),
		.result (res)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q <= in_value;
			last_q <= in_last;
			g_q <= init_q;
		end else if (cmd.write && done) begin
			unique case (cmd.step)
				nsr_pkg::STEP_G2:   g2_q <= res;
				nsr_pkg::STEP_G3:   g3_q <= res;
				nsr_pkg::STEP_E1:   e_q <= res;
				// fold in the absolute value: flip negative, nonzero, non-NaN
				nsr_pkg::STEP_E2:   e_q <= (res[31] && res[30:0] != 31'd0 &&
					!(res[30:23] == 8'hFF && res[22:0] != 23'd0)) ? {1'b0, res[30:0]} : res;
				nsr_pkg::STEP_D:    d_q <= res;
				nsr_pkg::STEP_A1:   a_q <= res;
				nsr_pkg::STEP_B:    b_q <= res;
				nsr_pkg::STEP_A2:   a_q <= res;
				nsr_pkg::STEP_G:    g_q <= res;
				nsr_pkg::STEP_ROOT: root_q <= res;
				default: ;
			endcase
		end
	end

	assign d_nan = (d_q[30:23] == 8'hFF) && (d_q[22:0] != 23'd0);
	assign sts.above = !d_q[31] && (d_q[30:0] != 31'd0) && !d_nan;
	assign sts.out_busy = m_valid && !m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid <= 1'b0;
		end else if (cmd.load_out) begin
			m_valid <= 1'b1;
		end else if (m_ready) begin
			m_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_root <= root_q;
			m_nc <= cmd.not_conv;
			m_last <= last_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/nsr_ctrl.sv
// Sequencer for the Newton iteration: issues float ops and counts rounds.
`default_nettype none
module nsr_ctrl #(
	parameter int unsigned MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire nsr_pkg::sts_t sts,
	output nsr_pkg::cmd_t      cmd
);

	localparam int unsigned RW = $clog2(MAX_ITERATIONS + 1);

	nsr_pkg::state_t state_q, state_d;
	nsr_pkg::step_t  step_q, step_d;
	logic [RW-1:0]   rounds_q, rounds_d;
	logic            nc_q, nc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsr_pkg::ST_IDLE;
			step_q <= nsr_pkg::STEP_G2;
			rounds_q <= '0;
			nc_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			rounds_q <= rounds_d;
			nc_q <= nc_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		rounds_d = rounds_q;
		nc_d = nc_q;
		cmd = '0;
		cmd.step = step_q;
		cmd.not_conv = nc_q;
		in_ready = 1'b0;
		unique case (state_q)
			nsr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					rounds_d = '0;
					nc_d = 1'b0;
					step_d = nsr_pkg::STEP_G2;
					state_d = nsr_pkg::ST_ISSUE;
				end
			end
			nsr_pkg::ST_ISSUE: begin
				cmd.issue = 1'b1;
				state_d = nsr_pkg::ST_WAIT;
			end
			nsr_pkg::ST_WAIT: state_d = nsr_pkg::ST_WB;
			nsr_pkg::ST_WB: begin
				cmd.write = 1'b1;
				state_d = nsr_pkg::ST_ISSUE;
				unique case (step_q)
					nsr_pkg::STEP_G2: step_d = nsr_pkg::STEP_G3;
					nsr_pkg::STEP_G3: step_d = nsr_pkg::STEP_E1;
					nsr_pkg::STEP_E1: step_d = nsr_pkg::STEP_E2;
					nsr_pkg::STEP_E2: step_d = nsr_pkg::STEP_D;
					nsr_pkg::STEP_D:  state_d = nsr_pkg::ST_TEST;
					nsr_pkg::STEP_A1: step_d = nsr_pkg::STEP_B;
					nsr_pkg::STEP_B:  step_d = nsr_pkg::STEP_A2;
					nsr_pkg::STEP_A2: step_d = nsr_pkg::STEP_G;
					nsr_pkg::STEP_G: begin
						step_d = nsr_pkg::STEP_G2;
						rounds_d = rounds_q + 1'b1;
					end
					nsr_pkg::STEP_ROOT: state_d = nsr_pkg::ST_OUT;
					default: state_d = nsr_pkg::ST_IDLE;
				endcase
			end
			nsr_pkg::ST_TEST: begin
				state_d = nsr_pkg::ST_ISSUE;
				if (!sts.above) begin
					step_d = nsr_pkg::STEP_ROOT;
				end else if (rounds_q >= RW'(MAX_ITERATIONS)) begin
					nc_d = 1'b1;
					step_d = nsr_pkg::STEP_ROOT;
				end else begin
					step_d = nsr_pkg::STEP_A1;
				end
			end
			nsr_pkg::ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = nsr_pkg::ST_IDLE;
				end
			end
			default: state_d = nsr_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/newton_square_root.sv
// Top level of the float32 Newton-Raphson square root block.
//
//  channel   direction  handshake                 content
//  s_axis    in         s_axis_tvalid/tready      value_bits, last_in
//  m_axis    out        m_axis_tvalid/tready      root_bits, not_converged, last_out
//  cfg       in         cfg_we (no wait)          initial_guess, error_threshold
//
// One transaction is worked at a time. Every float op goes through one shared
// three-stage multiply/subtract unit; setup and the error test take 5 ops and
// a test step, each refinement round 9 ops and a test step, the root 1 op, and
// the result is then loaded into the output register. Reset loads the default
// registers and empties the output. A stalled output holds only the result;
// the next transaction is accepted and worked while it waits.
`default_nettype none
module newton_square_root #(
	parameter int unsigned MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] value_bits
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] root_bits
	output logic [0:0]       m_axis_tuser,   // [0] not_converged
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_addr,
	input  wire logic [31:0] cfg_data
);

	nsr_pkg::cmd_t cmd;
	nsr_pkg::sts_t sts;

	// sequencer: steps the iteration, decides convergence
	nsr_ctrl #(
		.MAX_ITERATIONS (MAX_ITERATIONS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: operands, float unit, config and output registers
	nsr_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_value (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_root   (m_axis_tdata),
		.m_nc     (m_axis_tuser[0]),
		.m_last   (m_axis_tlast)
	);

endmodule
`default_nettype wire

// File: tb/tb_newton_square_root.sv
// Self-checking testbench for the float32 Newton-Raphson square root block.
`timescale 1ns / 1ps
module tb_newton_square_root;

	localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;
	localparam int unsigned ROUND_CAP = nsr_pkg::MAX_ITERATIONS_DEF;

	typedef struct {
		logic [31:0] root;
		logic        not_conv;
		logic        last;
	} root_result_t;

	// One row of the directed table; typed_out marks rows whose result is written in.
	typedef struct {
		logic [31:0] value;
		logic        last;
		logic        typed_out;
		logic [31:0] root;
		logic        not_conv;
	} directed_row_t;

	typedef struct {
		logic [31:0] guess;
		logic [31:0] thresh;
		int          n_items;
		logic        no_idle;
	} setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] value_bits
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [31:0] root_bits
	logic [0:0]  m_axis_tuser;        // [0] not_converged
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_addr = '0;
	logic [31:0] cfg_data = '0;

	// Shadow copy of the two configuration registers.
	logic [31:0] guess_reg = nsr_pkg::INITIAL_GUESS_RST;
	logic [31:0] thresh_reg = nsr_pkg::ERROR_THRESHOLD_RST;

	root_result_t pending_roots[$];
	int           err_count = 0;
	logic         no_idle = 1'b0;

	newton_square_root uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// float32 arithmetic: exact double product/difference, then one
	// round-to-nearest-even step back to single precision. NaN operands
	// propagate quieted (first operand wins), invalid ops give the default NaN.
	// ---------------------------------------------------------------
	function automatic logic is_nan(logic [31:0] f);
		return f[30:23] == 8'hFF && f[22:0] != 0;
	endfunction

	function automatic logic is_inf(logic [31:0] f);
		return f[30:23] == 8'hFF && f[22:0] == 0;
	endfunction

	function automatic logic is_zero(logic [31:0] f);
		return f[30:0] == 0;
	endfunction

	function automatic logic [63:0] widen(logic [31:0] f);
		int          ue;
		logic [23:0] sig;
		if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'b0};
		if (is_zero(f)) return {f[31], 63'b0};
		if (f[30:23] == 0) begin
			// subnormal: normalize into the wider exponent range
			sig = {1'b0, f[22:0]};
			ue = -126;
			while (!sig[23]) begin
				sig = sig << 1;
				ue--;
			end
		end else begin
			sig = {1'b1, f[22:0]};
			ue = int'(f[30:23]) - 127;
		end
		return {f[31], 11'(ue + 1023), sig[22:0], 29'b0};
	endfunction

	function automatic logic [31:0] narrow(logic [63:0] d);
		int          u;
		int          sh;
		logic [63:0] sig;
		logic [63:0] kept;
		logic [63:0] rem;
		logic [63:0] half;
		if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'b0};
		if (d[62:52] == 0) return {d[63], 31'b0};
		u = int'(d[62:52]) - 1023;
		sig = {11'b0, 1'b1, d[51:0]};
		sh = (u >= -126) ? 29 : 29 + (-126 - u);
		if (sh > 60) return {d[63], 31'b0};
		kept = sig >> sh;
		rem = sig & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && kept[0])) kept++;
		if (u >= -126) begin
			if (kept[24]) begin
				kept = kept >> 1;
				u++;
			end
			if (u > 127) return {d[63], 8'hFF, 23'b0};
			return {d[63], 8'(u + 127), kept[22:0]};
		end
		// a carry out of the subnormal field lands on the smallest normal
		return {d[63], 31'b0} + kept[31:0];
	endfunction

	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		if (is_nan(a)) return a | nsr_pkg::FP_QBIT;
		if (is_nan(b)) return b | nsr_pkg::FP_QBIT;
		if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return nsr_pkg::FP_DNAN;
		return narrow($realtobits($bitstoreal(widen(a)) * $bitstoreal(widen(b))));
	endfunction

	function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
		if (is_nan(a)) return a | nsr_pkg::FP_QBIT;
		if (is_nan(b)) return b | nsr_pkg::FP_QBIT;
		if (is_inf(a) && is_inf(b) && a[31] == b[31]) return nsr_pkg::FP_DNAN;
		return narrow($realtobits($bitstoreal(widen(a)) - $bitstoreal(widen(b))));
	endfunction

	// |x*g2 - 1|; the sign flip is a multiply by -1 and skips NaN and zero.
	function automatic logic [31:0] residual(logic [31:0] x, logic [31:0] g2);
		logic [31:0] e;
		e = fp_sub(fp_mul(x, g2), nsr_pkg::FP_ONE);
		if (!is_nan(e) && e[31] && !is_zero(e)) e = fp_mul(e, FP_NEG_ONE);
		return e;
	endfunction

	// Ordered compare: (err - thr) > 0, false whenever a NaN is involved.
	function automatic logic exceeds(logic [31:0] err, logic [31:0] thr);
		logic [31:0] d;
		d = fp_sub(err, thr);
		return !is_nan(d) && !d[31] && !is_zero(d);
	endfunction

	function automatic root_result_t newton_root(logic [31:0] x, logic last);
		root_result_t r;
		logic [31:0]  g;
		logic [31:0]  g2;
		logic [31:0]  g3;
		logic [31:0]  err;
		logic [31:0]  a;
		int unsigned  rounds;
		g = guess_reg;
		g2 = fp_mul(g, g);
		g3 = fp_mul(g2, g);
		err = residual(x, g2);
		rounds = 0;
		r.not_conv = 1'b0;
		while (exceeds(err, thresh_reg)) begin
			if (rounds >= ROUND_CAP) begin
				r.not_conv = 1'b1;
				break;
			end
			a = fp_sub(fp_mul(g, nsr_pkg::FP_THREE), fp_mul(x, g3));
			g = fp_mul(a, nsr_pkg::FP_HALF);
			g2 = fp_mul(g, g);
			g3 = fp_mul(g2, g);
			err = residual(x, g2);
			rounds++;
		end
		r.root = fp_mul(g, x);
		r.last = last;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch, got %h, expected %h", $realtime, field, got, want);
		err_count++;
	endtask

	// Compare every output transaction with the oldest expectation.
	always @(posedge clk) begin
		root_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_roots.size() == 0) begin
				report_mismatch("unexpected result, root", m_axis_tdata, 32'h0);
			end else begin
				want = pending_roots.pop_front();
				if (m_axis_tdata !== want.root)
					report_mismatch("root_bits", m_axis_tdata, want.root);
				if (m_axis_tuser[0] !== want.not_conv)
					report_mismatch("not_converged", 32'(m_axis_tuser[0]), 32'(want.not_conv));
				if (m_axis_tlast !== want.last)
					report_mismatch("last_out", 32'(m_axis_tlast), 32'(want.last));
			end
		end
	end

	// Receiver backpressure: random stall bursts, none once no_idle is set.
	initial begin
		@(posedge arst_n);
		forever begin
			if (!no_idle && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// Offer one input transaction, holding it until accepted, and log its result.
	task automatic send_value(logic [31:0] value, logic last, logic typed,
			root_result_t typed_out);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_roots.push_back(typed ? typed_out : newton_root(value, last));
	endtask

	// Drain, then load both registers while the block is idle.
	task automatic load_setting(logic [31:0] guess, logic [31:0] thresh);
		s_axis_tvalid <= 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= nsr_pkg::REG_INITIAL_GUESS;
		cfg_data <= guess;
		@(posedge clk);
		cfg_addr <= nsr_pkg::REG_ERROR_THRESHOLD;
		cfg_data <= thresh;
		@(posedge clk);
		cfg_we <= 1'b0;
		guess_reg = guess;
		thresh_reg = thresh;
		@(posedge clk);
	endtask

	// Mostly values where the iteration converges, plus raw patterns and specials.
	function automatic logic [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return {r < 5, 8'($urandom_range(118, 131)), 23'($urandom)};
		if (r < 85)
			return $urandom;
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7F80_0000;
			3: return 32'hFF80_0000;
			4: return 32'h7FC0_0000 | 32'($urandom_range(0, 32'h3F_FFFF));
			5: return 32'h7F80_0001 | 32'($urandom_range(0, 32'h3F_FFFF));
			6: return 32'h0000_0001;
			7: return 32'h007F_FFFF;
			8: return 32'h7F7F_FFFF;
			default: return 32'h0080_0000;
		endcase
	endfunction

	initial begin
		directed_row_t directed[$];
		setting_t      settings[$];
		root_result_t  typed_out;
		directed = '{
			// unity converges at once from the reset guess
			'{32'h3F80_0000, 1'b0, 1'b1, 32'h3F80_0000, 1'b0},
			'{32'h3F80_0000, 1'b1, 1'b1, 32'h3F80_0000, 1'b0},
			'{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0},     // zero: guess grows, cap hit
			'{32'h8000_0000, 1'b1, 1'b0, 32'h0, 1'b0},     // negative zero
			'{32'h7F80_0000, 1'b0, 1'b0, 32'h0, 1'b0},     // +inf
			'{32'hFF80_0000, 1'b0, 1'b0, 32'h0, 1'b0},     // -inf
			'{32'h7FC0_0001, 1'b1, 1'b0, 32'h0, 1'b0},     // quiet NaN ends the loop
			'{32'h7F80_0001, 1'b0, 1'b0, 32'h0, 1'b0},     // signaling NaN
			'{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},     // all ones
			'{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0},     // smallest subnormal
			'{32'h007F_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},     // largest subnormal
			'{32'h7F7F_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},     // largest finite
			'{32'h4080_0000, 1'b0, 1'b0, 32'h0, 1'b0},     // 4.0
			'{32'h4000_0000, 1'b1, 1'b0, 32'h0, 1'b0},     // 2.0
			'{32'h3E80_0000, 1'b0, 1'b0, 32'h0, 1'b0},     // 0.25
			'{32'hC080_0000, 1'b0, 1'b0, 32'h0, 1'b0},     // negative value
			'{32'h3F80_0001, 1'b0, 1'b0, 32'h0, 1'b0},     // one ulp above unity
			'{32'h3F7F_FFFF, 1'b1, 1'b0, 32'h0, 1'b0}      // one ulp below unity
		};
		settings = '{
			'{nsr_pkg::INITIAL_GUESS_RST, nsr_pkg::ERROR_THRESHOLD_RST, 380, 1'b0},
			'{32'h3F00_0000, 32'h3A83_126F, 300, 1'b0},   // guess 0.5, threshold 1e-3
			'{32'h0000_0000, 32'h0000_0000, 8, 1'b0},     // zero guess never moves
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 60, 1'b0},    // NaN guess and threshold
			'{32'h3E80_0000, 32'h7F80_0000, 120, 1'b0},   // infinite threshold
			'{nsr_pkg::INITIAL_GUESS_RST, 32'h0000_0001, 200, 1'b0}, // tiny threshold
			'{32'h3F35_04F3, nsr_pkg::ERROR_THRESHOLD_RST, 380, 1'b1}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset register values.
		foreach (directed[i]) begin
			typed_out = '{directed[i].root, directed[i].not_conv, directed[i].last};
			send_value(directed[i].value, directed[i].last, directed[i].typed_out,
				typed_out);
		end

		// Random transactions under each register setting in turn.
		foreach (settings[p]) begin
			load_setting(settings[p].guess, settings[p].thresh);
			no_idle = settings[p].no_idle;
			repeat (settings[p].n_items)
				send_value(pick_value(), $urandom_range(0, 7) == 0, 1'b0, typed_out);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_roots.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_newton_square_root: clean");
		end else begin
			$display("tb_newton_square_root: errors");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("tb_newton_square_root: errors");
		$finish;
	end

endmodule
